[rtl/core/pu_pkg.sv]
// Shared types, constants and the factorial table for the permutation unranking core.
`timescale 1ns / 1ps

package pu_pkg;

	localparam int RANK_W = 64;
	localparam int ELEM_W = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_DIGIT,
		ST_EMIT
	} pu_state_t;

	typedef struct packed {
		logic init;
		logic remove;
	} pu_pool_ctrl_t;

	// Factorials 0! to 20!; larger indexes are never used.
	function automatic logic [RANK_W-1:0] fact_f(input logic [ELEM_W-1:0] idx);
		logic [RANK_W-1:0] f;
		case (idx)
			5'd0:    f = 64'd1;
			5'd1:    f = 64'd1;
			5'd2:    f = 64'd2;
			5'd3:    f = 64'd6;
			5'd4:    f = 64'd24;
			5'd5:    f = 64'd120;
			5'd6:    f = 64'd720;
			5'd7:    f = 64'd5040;
			5'd8:    f = 64'd40320;
			5'd9:    f = 64'd362880;
			5'd10:   f = 64'd3628800;
			5'd11:   f = 64'd39916800;
			5'd12:   f = 64'd479001600;
			5'd13:   f = 64'd6227020800;
			5'd14:   f = 64'd87178291200;
			5'd15:   f = 64'd1307674368000;
			5'd16:   f = 64'd20922789888000;
			5'd17:   f = 64'd355687428096000;
			5'd18:   f = 64'd6402373705728000;
			5'd19:   f = 64'd121645100408832000;
			5'd20:   f = 64'd2432902008176640000;
			default: f = 64'd1;
		endcase
		return f;
	endfunction

endpackage

[rtl/core/pu_csub.sv]
// Shared 64-bit compare-and-subtract unit.
`timescale 1ns / 1ps

module pu_csub import pu_pkg::*; (
	input  logic [RANK_W-1:0] a,
	input  logic [RANK_W-1:0] b,
	output logic [RANK_W-1:0] diff,
	output logic              ge
);

	logic [RANK_W:0] wide;

	always_comb begin
		wide = {1'b0, a} - {1'b0, b};
		diff = wide[RANK_W-1:0];
		ge   = ~wide[RANK_W];
	end

endmodule

[rtl/core/pu_pool.sv]
// Pool of unused elements in ascending order, with pick and remove.
`timescale 1ns / 1ps

module pu_pool import pu_pkg::*; #(
	parameter int DEPTH = 20
) (
	input  logic              clk,
	input  pu_pool_ctrl_t     ctrl,
	input  logic [ELEM_W-1:0] sel,
	output logic [ELEM_W-1:0] picked
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [ELEM_W-1:0] pool_q [DEPTH];
	logic [IDX_W-1:0]  sel_idx;

	assign sel_idx = sel[IDX_W-1:0];
	assign picked  = pool_q[sel_idx];

	always_ff @(posedge clk) begin
		for (int j = 0; j < DEPTH; j++) begin
			if (ctrl.init) begin
				pool_q[j] <= ELEM_W'(j);
			end else if (ctrl.remove && (ELEM_W'(j) >= sel) && (j + 1 < DEPTH)) begin
				// close the gap left by the taken element
				pool_q[j] <= pool_q[(j + 1) % DEPTH];
			end
		end
	end

endmodule

[rtl/core/permutation_unrank_core.sv]
// Top level: lexicographic permutation unranking over a shared compare-subtract unit.
//
// channel   direction  signals                                         handshake
// input     in         in_valid, in_ready, perm_rank                   valid/ready
// output    out        out_valid, out_ready, element_value,
//                      element_position, last_element                  valid/ready
// config    in         cfg_wr_en, cfg_wr_data                          write enable
//
// One request first reduces the rank modulo n! in the bit-serial compare-subtract
// loop, then finds the factorial digit d of each position (d at most n-1) by repeated
// subtraction and emits the picked element; any output stall lengthens the request.
// Reset clears the control state and sets the size register to 1.
// A stalled result holds the sequencer in its emit state; no new request is taken
// until the last element of the permutation has been taken.
`timescale 1ns / 1ps

module permutation_unrank_core import pu_pkg::*; #(
	parameter int MAX_SIZE = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ELEM_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [RANK_W-1:0] perm_rank,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ELEM_W-1:0] element_value,
	output logic [ELEM_W-1:0] element_position,
	output logic              last_element
);

	localparam logic [ELEM_W-1:0] MAX_N = ELEM_W'(MAX_SIZE);

	pu_state_t         state_q, state_d;
	logic [ELEM_W-1:0] perm_size_q;
	logic [ELEM_W-1:0] eff_n;
	logic [RANK_W-1:0] rank_q;
	logic [RANK_W-1:0] rem_q;
	logic [5:0]        bit_cnt_q;
	logic [ELEM_W-1:0] k_q;
	logic [ELEM_W-1:0] digit_q;
	logic [ELEM_W-1:0] pos_q;
	logic [ELEM_W-1:0] value_q;
	logic [ELEM_W-1:0] position_q;
	logic              last_q;

	logic [RANK_W-1:0] op_a, op_b, sub_diff;
	logic              sub_ge;
	logic [ELEM_W-1:0] picked;
	logic              digit_done;
	pu_pool_ctrl_t     pool_ctrl;
	logic              in_acc, out_acc;

	always_comb begin
		eff_n = perm_size_q;
		if (eff_n == '0) begin
			eff_n = ELEM_W'(1);
		end
		if (eff_n > MAX_N) begin
			eff_n = MAX_N;
		end
	end

	// modulo phase shifts the rank in bit by bit against n!; digit phase tries (k-1)!
	always_comb begin
		if (state_q == ST_MOD) begin
			op_a = {rem_q[RANK_W-2:0], rank_q[RANK_W-1]};
			op_b = fact_f(k_q);
		end else begin
			op_a = rem_q;
			op_b = fact_f(k_q - ELEM_W'(1));
		end
	end

	pu_csub u_csub (
		.a    (op_a),
		.b    (op_b),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	pu_pool #(.DEPTH(MAX_SIZE)) u_pool (
		.clk    (clk),
		.ctrl   (pool_ctrl),
		.sel    (digit_q),
		.picked (picked)
	);

	assign in_acc     = in_valid && in_ready;
	assign out_acc    = out_valid && out_ready;
	assign digit_done = !(sub_ge && (digit_q < k_q - ELEM_W'(1)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MOD;
			end
			ST_MOD: begin
				if (bit_cnt_q == '0) state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (digit_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready) state_d = last_q ? ST_IDLE : ST_DIGIT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready         = 1'b0;
		out_valid        = 1'b0;
		pool_ctrl.init   = 1'b0;
		pool_ctrl.remove = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				pool_ctrl.init = in_valid;
			end
			ST_EMIT: begin
				out_valid        = 1'b1;
				pool_ctrl.remove = out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			perm_size_q <= ELEM_W'(1);
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				perm_size_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					rank_q    <= perm_rank;
					rem_q     <= '0;
					bit_cnt_q <= 6'd63;
					k_q       <= eff_n;
					digit_q   <= '0;
					pos_q     <= '0;
				end
			end
			ST_MOD: begin
				rank_q    <= {rank_q[RANK_W-2:0], 1'b0};
				rem_q     <= sub_ge ? sub_diff : op_a;
				bit_cnt_q <= bit_cnt_q - 6'd1;
			end
			ST_DIGIT: begin
				if (!digit_done) begin
					rem_q   <= sub_diff;
					digit_q <= digit_q + ELEM_W'(1);
				end else begin
					value_q    <= picked;
					position_q <= pos_q;
					last_q     <= (k_q == ELEM_W'(1));
				end
			end
			ST_EMIT: begin
				// advance to the next position once the element is taken
				if (out_acc) begin
					k_q     <= k_q - ELEM_W'(1);
					pos_q   <= pos_q + ELEM_W'(1);
					digit_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign element_value    = value_q;
	assign element_position = position_q;
	assign last_element     = last_q;

endmodule
